// File: hw/rtl/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types, markers, command codes and reply byte table for the serial
// command frame responder.
// ----------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

  localparam logic [7:0] MARK_START = 8'hde;
  localparam logic [7:0] MARK_END   = 8'had;

  localparam logic [7:0] CMD_GET_REV  = 8'h01;
  localparam logic [7:0] CMD_DUMP     = 8'h03;
  localparam logic [7:0] CMD_QUIET_LO = 8'h04;
  localparam logic [7:0] CMD_QUIET_HI = 8'h08;
  localparam logic [7:0] CMD_HALT     = 8'hfe;

  localparam logic [7:0] RSP_VERSION = 8'h02;
  localparam logic [7:0] RSP_NAK     = 8'hff;
  localparam logic [7:0] VERSION_NUM = 8'h01;

  localparam logic [7:0] LEN_WITH_PAYLOAD = 8'h05;
  localparam logic [7:0] LEN_EMPTY        = 8'h04;
  localparam logic [7:0] MIN_FRAME_LEN    = 8'h03;

  localparam int POS_W = 3;

  localparam logic [POS_W-1:0] POS_START   = 3'd0;
  localparam logic [POS_W-1:0] POS_LENGTH  = 3'd1;
  localparam logic [POS_W-1:0] POS_COMMAND = 3'd2;
  localparam logic [POS_W-1:0] POS_THIRD   = 3'd3;
  localparam logic [POS_W-1:0] POS_FOURTH  = 3'd4;

  typedef enum logic [1:0] {
    REPLY_VERSION = 2'd0,
    REPLY_STOP    = 2'd1,
    REPLY_DUMP    = 2'd2,
    REPLY_NAK     = 2'd3
  } reply_kind_t;

  typedef struct packed {
    logic        valid;
    reply_kind_t kind;
  } reply_req_t;

  function automatic logic [POS_W-1:0] reply_last_pos(input reply_kind_t kind);
    reply_last_pos = (kind == REPLY_VERSION) ? POS_FOURTH : POS_THIRD;
  endfunction

  function automatic logic [7:0] reply_command(input reply_kind_t kind);
    case (kind)
      REPLY_VERSION: reply_command = RSP_VERSION;
      REPLY_STOP:    reply_command = CMD_HALT;
      REPLY_DUMP:    reply_command = CMD_DUMP;
      default:       reply_command = RSP_NAK;
    endcase
  endfunction

  function automatic logic [7:0] reply_byte(input reply_kind_t kind,
                                            input logic [POS_W-1:0] pos);
    case (pos)
      POS_START:   reply_byte = MARK_START;
      POS_LENGTH:  reply_byte = (kind == REPLY_VERSION) ? LEN_WITH_PAYLOAD : LEN_EMPTY;
      POS_COMMAND: reply_byte = reply_command(kind);
      POS_THIRD:   reply_byte = (kind == REPLY_VERSION) ? VERSION_NUM : MARK_END;
      default:     reply_byte = MARK_END;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scfr_parser.sv
// ----------------------------------------------------------------------------
// scfr_parser
// Frame hunter and byte counter. Checks each accepted byte against the stored
// length and end marker and requests a reply on completion of a non-quiet frame.
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_parser #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         rx_byte,
  output scfr_pkg::reply_req_t    req
);

  localparam logic [8:0] MAX_CNT = 9'(MAX_FRAME_BYTES);

  logic [7:0] byte_count;
  logic [7:0] frame_length;
  logic [7:0] command_code;

  logic [7:0] byte_count_next;
  logic [7:0] frame_length_next;
  logic [7:0] command_code_next;

  logic       start_ok;
  logic [7:0] len_eff;
  logic [7:0] cmd_eff;
  logic [8:0] cnt;
  logic       complete;
  logic       quiet;

  always_comb begin
    start_ok = (byte_count != 8'd0) || (rx_byte == scfr_pkg::MARK_START);
    len_eff  = (byte_count == 8'd1) ? rx_byte : frame_length;
    cmd_eff  = (byte_count == 8'd2) ? rx_byte : command_code;
    cnt      = {1'b0, byte_count} + 9'd1;
    complete = start_ok && (len_eff >= scfr_pkg::MIN_FRAME_LEN) &&
               (cnt == {1'b0, len_eff}) && (rx_byte == scfr_pkg::MARK_END);
    quiet    = (cmd_eff >= scfr_pkg::CMD_QUIET_LO) && (cmd_eff <= scfr_pkg::CMD_QUIET_HI);

    frame_length_next = len_eff;
    command_code_next = cmd_eff;
    if (complete || (cnt >= MAX_CNT)) begin
      byte_count_next = 8'd0;
    end else begin
      byte_count_next = cnt[7:0];
    end

    req.valid = accept && complete && !quiet;
    case (cmd_eff)
      scfr_pkg::CMD_GET_REV: req.kind = scfr_pkg::REPLY_VERSION;
      scfr_pkg::CMD_DUMP:    req.kind = scfr_pkg::REPLY_DUMP;
      scfr_pkg::CMD_HALT:    req.kind = scfr_pkg::REPLY_STOP;
      default:               req.kind = scfr_pkg::REPLY_NAK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= 8'd0;
      frame_length <= 8'd0;
      command_code <= 8'd0;
    end else if (accept && start_ok) begin
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      command_code <= command_code_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scfr_reply_tx.sv
// ----------------------------------------------------------------------------
// scfr_reply_tx
// Reply sender. One queued request slot in front of the active reply; the
// active reply is walked out one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_reply_tx (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire scfr_pkg::reply_req_t req,
  output logic                      full,
  output logic                      tx_valid,
  input  wire logic                 tx_stall,
  output logic [7:0]                tx_byte,
  output logic                      tx_last
);

  logic                              pend_valid;
  scfr_pkg::reply_kind_t             pend_kind;
  logic                              busy;
  scfr_pkg::reply_kind_t             kind;
  logic [scfr_pkg::POS_W-1:0]        pos;

  logic                              done;
  logic                              move;

  always_comb begin
    tx_valid = busy;
    tx_byte  = scfr_pkg::reply_byte(kind, pos);
    tx_last  = (pos == scfr_pkg::reply_last_pos(kind));
    done     = busy && !tx_stall && tx_last;
    move     = pend_valid && (!busy || done);
    full     = pend_valid && busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      busy       <= 1'b0;
      pos        <= scfr_pkg::POS_START;
    end else begin
      if (req.valid) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        busy <= 1'b1;
        pos  <= scfr_pkg::POS_START;
      end else if (done) begin
        busy <= 1'b0;
        pos  <= scfr_pkg::POS_START;
      end else if (busy && !tx_stall) begin
        pos  <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      pend_kind <= req.kind;
    end
    if (move) begin
      kind <= pend_kind;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/serial_command_frame_responder_top.sv
// ----------------------------------------------------------------------------
// serial_command_frame_responder_top
// A closing byte accepted fills the pending reply slot, which then moves into
// the active reply to show its first word; the reply follows at one word per
// cycle without stall. Throughput: one received byte per cycle; input stalls
// only while a second reply waits behind an active one. Reset empties the
// reply slots and returns the parser to hunting for a start marker.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_frame_responder_top #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            tx_valid,
  input  wire logic       tx_stall,
  output logic [7:0]      tx_byte,
  output logic            tx_last
);

  scfr_pkg::reply_req_t req;
  logic                 full;
  logic                 accept;

  assign rx_stall = full;
  assign accept   = rx_valid && !full;

  scfr_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .req     (req)
  );

  scfr_reply_tx u_reply_tx (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .full     (full),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_byte  (tx_byte),
    .tx_last  (tx_last)
  );

endmodule

`default_nettype wire
